// File: src/ttfp_pkg.sv
// ============================================================================
// ttfp_pkg
// Shared types and constants for the telemetry text field parser.
// ============================================================================
`default_nettype none

package ttfp_pkg;

    // Field and value sizes.
    localparam int NUM_FIELDS = 9;
    localparam int VAL_W      = 25;
    localparam int ACC_W      = 24;
    localparam int CNT_W      = 4;
    localparam int FRAC_W     = 3;

    // Magnitude ceiling of any parsed value.
    localparam logic [ACC_W-1:0] VALUE_LIMIT = 24'd9999900;

    // Field indexes that have special handling.
    localparam logic [3:0] IDX_PACKET   = 4'd0;
    localparam logic [3:0] IDX_PRESSURE = 4'd6;
    localparam logic [3:0] IDX_RSSI     = 4'd7;
    localparam logic [3:0] IDX_SNR      = 4'd8;

    // ASCII codes.
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Parser position within a record.
    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_SKIP     = 4'd1,
        ST_FIELD1   = 4'd2,
        ST_FIELD2   = 4'd3,
        ST_FIELD3   = 4'd4,
        ST_FIELD4   = 4'd5,
        ST_FIELD5   = 4'd6,
        ST_FIELD6   = 4'd7,
        ST_PRESSURE = 4'd8,
        ST_SEEK     = 4'd9,
        ST_RSSI     = 4'd10,
        ST_SNR      = 4'd11,
        ST_DROP     = 4'd12
    } stage_t;

    // Running state of the number being read.
    typedef struct packed {
        logic              started;
        logic              neg;
        logic              point;
        logic              stop;
        logic [FRAC_W-1:0] frac;
        logic [CNT_W-1:0]  cnt;
        logic [ACC_W-1:0]  acc;
    } num_t;

    localparam num_t NUM_CLEAR = '0;

    // Powers of ten for the fraction scale.
    function automatic logic [13:0] pow10(input logic [FRAC_W-1:0] n);
        logic [13:0] p;
        case (n)
            3'd0:    p = 14'd1;
            3'd1:    p = 14'd10;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd1000;
            3'd4:    p = 14'd10000;
            default: p = 14'd0;
        endcase
        return p;
    endfunction

    // Clamp a wide magnitude to the value ceiling.
    function automatic logic [ACC_W-1:0] sat(input logic [27:0] v);
        logic [ACC_W-1:0] r;
        if (v > {4'd0, VALUE_LIMIT})
        begin
            r = VALUE_LIMIT;
        end
        else
        begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    // Signed value of a finished number.
    function automatic logic signed [VAL_W-1:0] to_signed(input num_t n);
        logic signed [VAL_W-1:0] m;
        m = $signed({1'b0, n.acc});
        return n.neg ? -m : m;
    endfunction

endpackage

`default_nettype wire

// File: src/ttfp_num_feed.sv
// ============================================================================
// ttfp_num_feed
// Folds one character into the running decimal number of a field.
// ============================================================================
`default_nettype none

module ttfp_num_feed #(
    parameter int FRACTION_DIGITS = 2
) (
    input  wire logic [7:0]                  char_in,
    input  wire logic [ttfp_pkg::CNT_W-1:0]  limit,
    input  wire ttfp_pkg::num_t              num_cur,
    output ttfp_pkg::num_t                   num_nxt
);
    import ttfp_pkg::*;

    logic             is_ws;
    logic             is_digit;
    logic [3:0]       digit;
    logic [17:0]      int_add;
    logic [17:0]      frac_add;
    logic [27:0]      scaled;
    logic [ACC_W-1:0] scaled_sat;
    logic [FRAC_W-1:0] frac_exp;

    assign is_ws    = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign digit    = 4'(char_in - CH_ZERO);
    assign frac_exp = FRAC_W'(FRACTION_DIGITS - 1) - num_cur.frac;
    assign int_add  = 18'(digit) * 18'(pow10(FRAC_W'(FRACTION_DIGITS)));
    assign frac_add = 18'(digit) * 18'(pow10(frac_exp));
    assign scaled     = 28'(num_cur.acc) * 28'd10;
    assign scaled_sat = sat(scaled);

    always_comb
    begin
        num_nxt = num_cur;
        if (!num_cur.stop && (num_cur.cnt < limit))
        begin
            num_nxt.cnt = num_cur.cnt + 1'b1;
            if (!num_cur.started && is_ws)
            begin
                // Leading white space only uses up a character.
            end
            else if (!num_cur.started && (char_in == CH_PLUS || char_in == CH_MINUS))
            begin
                num_nxt.started = 1'b1;
                num_nxt.neg     = (char_in == CH_MINUS);
            end
            else if (is_digit)
            begin
                num_nxt.started = 1'b1;
                if (!num_cur.point)
                begin
                    num_nxt.acc = sat(28'(scaled_sat) + 28'(int_add));
                end
                else if (num_cur.frac < FRAC_W'(FRACTION_DIGITS))
                begin
                    num_nxt.acc  = sat(28'(num_cur.acc) + 28'(frac_add));
                    num_nxt.frac = num_cur.frac + 1'b1;
                end
            end
            else if (char_in == CH_DOT && !num_cur.point)
            begin
                num_nxt.started = 1'b1;
                num_nxt.point   = 1'b1;
            end
            else
            begin
                num_nxt.stop = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/telemetry_text_field_parser.sv
// ============================================================================
// telemetry_text_field_parser
// Parses a telemetry text record, one character per transaction, into nine
// fixed point fields and reports them when the record ends.
// ============================================================================
// The result for a character marked last is registered and shown in the cycle
// after that character is accepted.
// Throughput: one character per cycle; input is stalled only while a result
// waits on the output.
// Reset: asynchronous, active low; parser returns to awaiting a record and all
// held and pending values read as zero.
`default_nettype none

module telemetry_text_field_parser #(
    parameter int LONG_FIELD_CHARS     = 5,
    parameter int SHORT_FIELD_CHARS    = 3,
    parameter int PRESSURE_FIELD_CHARS = 4,
    parameter int FRACTION_DIGITS      = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         char_byte,
    input  wire logic               last_char,
    input  wire logic [3:0]         field_select,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    record_valid,
    output logic signed [24:0]      selected_value,
    output logic signed [24:0]      packet_number_value,
    output logic signed [24:0]      light_value,
    output logic signed [24:0]      cpu_temp_value,
    output logic signed [24:0]      avg_temp_value,
    output logic signed [24:0]      humidity_value,
    output logic signed [24:0]      accel_value,
    output logic signed [24:0]      pressure_value,
    output logic signed [24:0]      rssi_value,
    output logic signed [24:0]      snr_value
);
    import ttfp_pkg::*;

    // Parser state.
    stage_t     stage_reg, stage_next;
    logic [1:0] skip_cnt_reg, skip_cnt_next;
    num_t       num_reg, num_next;

    // Values of the record in progress, and of the last complete record.
    logic signed [VAL_W-1:0] pending_reg [NUM_FIELDS];
    logic signed [VAL_W-1:0] pending_next [NUM_FIELDS];
    logic signed [VAL_W-1:0] held_reg [NUM_FIELDS];
    logic signed [VAL_W-1:0] held_next [NUM_FIELDS];

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic                    record_valid_reg, record_valid_next;
    logic signed [VAL_W-1:0] selected_reg, selected_next;

    logic             accept;
    logic [3:0]       field_idx;
    logic [CNT_W-1:0] field_limit;
    num_t             num_fed;
    stage_t           stage_mid;
    num_t             num_mid;

    // The input side moves whenever the result register is empty or being
    // drained in this same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Which field the current character belongs to.
    always_comb
    begin
        case (stage_reg)
            ST_RSSI: field_idx = IDX_RSSI;
            ST_SNR:  field_idx = IDX_SNR;
            default: field_idx = 4'(stage_reg - ST_FIELD1);
        endcase
    end

    always_comb
    begin
        if (field_idx == IDX_PACKET)
        begin
            field_limit = CNT_W'(LONG_FIELD_CHARS);
        end
        else if (field_idx == IDX_PRESSURE)
        begin
            field_limit = CNT_W'(PRESSURE_FIELD_CHARS);
        end
        else
        begin
            field_limit = CNT_W'(SHORT_FIELD_CHARS);
        end
    end

    ttfp_num_feed #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_num_feed (
        .char_in (char_byte),
        .limit   (field_limit),
        .num_cur (num_reg),
        .num_nxt (num_fed)
    );

    // Record walk: first the character itself moves the parser, then a marked
    // record end reports a result and, if SNR was reached, closes SNR and commits.
    always_comb
    begin
        stage_next        = stage_reg;
        skip_cnt_next     = skip_cnt_reg;
        num_next          = num_reg;
        pending_next      = pending_reg;
        held_next         = held_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        record_valid_next = record_valid_reg;
        selected_next     = selected_reg;
        stage_mid         = stage_reg;
        num_mid           = num_reg;

        if (accept)
        begin
            case (stage_reg)
                ST_IDLE:
                begin
                    stage_mid     = (char_byte == CH_P) ? ST_SKIP : ST_DROP;
                    skip_cnt_next = 2'd0;
                    num_mid       = NUM_CLEAR;
                end
                ST_SKIP:
                begin
                    skip_cnt_next = skip_cnt_reg + 1'b1;
                    if (skip_cnt_reg == 2'd1)
                    begin
                        stage_mid = ST_FIELD1;
                        num_mid   = NUM_CLEAR;
                    end
                end
                ST_FIELD1, ST_FIELD2, ST_FIELD3, ST_FIELD4, ST_FIELD5, ST_FIELD6:
                begin
                    if (char_byte == CH_COMMA)
                    begin
                        pending_next[field_idx] = to_signed(num_reg);
                        num_mid   = NUM_CLEAR;
                        stage_mid = stage_t'(stage_reg + 4'd1);
                    end
                    else
                    begin
                        num_mid = num_fed;
                    end
                end
                ST_PRESSURE:
                begin
                    if (char_byte == CH_SEMI)
                    begin
                        pending_next[IDX_PRESSURE] = to_signed(num_reg);
                        num_mid   = NUM_CLEAR;
                        stage_mid = ST_SEEK;
                    end
                    else
                    begin
                        num_mid = num_fed;
                    end
                end
                ST_SEEK:
                begin
                    if (char_byte == CH_MINUS)
                    begin
                        stage_mid = ST_RSSI;
                        num_mid   = NUM_CLEAR;
                    end
                end
                ST_RSSI:
                begin
                    if (char_byte == CH_COMMA)
                    begin
                        pending_next[IDX_RSSI] = to_signed(num_reg);
                        num_mid   = NUM_CLEAR;
                        stage_mid = ST_SNR;
                    end
                    else
                    begin
                        num_mid = num_fed;
                    end
                end
                ST_SNR:
                begin
                    num_mid = num_fed;
                end
                default:
                begin
                    // Rest of a record that did not start with P.
                end
            endcase

            stage_next = stage_mid;
            num_next   = num_mid;

            if (last_char)
            begin
                record_valid_next = (stage_mid == ST_SNR);
                if (stage_mid == ST_SNR)
                begin
                    pending_next[IDX_SNR] = to_signed(num_mid);
                    held_next = pending_next;
                end
                stage_next     = ST_IDLE;
                skip_cnt_next  = 2'd0;
                num_next       = NUM_CLEAR;
                out_valid_next = 1'b1;

                if (field_select >= 4'd1 && field_select <= 4'(NUM_FIELDS))
                begin
                    selected_next = held_next[4'(field_select - 4'd1)];
                end
                else
                begin
                    selected_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg        <= ST_IDLE;
            skip_cnt_reg     <= 2'd0;
            num_reg          <= NUM_CLEAR;
            out_valid_reg    <= 1'b0;
            record_valid_reg <= 1'b0;
            selected_reg     <= '0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                pending_reg[i] <= '0;
                held_reg[i]    <= '0;
            end
        end
        else
        begin
            stage_reg        <= stage_next;
            skip_cnt_reg     <= skip_cnt_next;
            num_reg          <= num_next;
            out_valid_reg    <= out_valid_next;
            record_valid_reg <= record_valid_next;
            selected_reg     <= selected_next;
            pending_reg      <= pending_next;
            held_reg         <= held_next;
        end
    end

    // The held values only move together with a new result, so they serve
    // directly as the per-field part of the result register.
    assign out_valid           = out_valid_reg;
    assign record_valid        = record_valid_reg;
    assign selected_value      = selected_reg;
    assign packet_number_value = held_reg[0];
    assign light_value         = held_reg[1];
    assign cpu_temp_value      = held_reg[2];
    assign avg_temp_value      = held_reg[3];
    assign humidity_value      = held_reg[4];
    assign accel_value         = held_reg[5];
    assign pressure_value      = held_reg[6];
    assign rssi_value          = held_reg[7];
    assign snr_value           = held_reg[8];

endmodule

`default_nettype wire

// File: src/ttfp_checker.sv
// ============================================================================
// ttfp_checker
// Port-level checks for the telemetry text field parser.
// ============================================================================
`default_nettype none

module ttfp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [7:0]         char_byte,
    input wire logic               last_char,
    input wire logic [3:0]         field_select,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               record_valid,
    input wire logic signed [24:0] selected_value,
    input wire logic signed [24:0] packet_number_value,
    input wire logic signed [24:0] light_value,
    input wire logic signed [24:0] cpu_temp_value,
    input wire logic signed [24:0] avg_temp_value,
    input wire logic signed [24:0] humidity_value,
    input wire logic signed [24:0] accel_value,
    input wire logic signed [24:0] pressure_value,
    input wire logic signed [24:0] rssi_value,
    input wire logic signed [24:0] snr_value
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_valid)
            && $stable(selected_value) && $stable(snr_value))
        else $error("result changed while stalled");

    // A pending, untaken result blocks the input side.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted over a stalled result");

    // Only the last character of a record produces a transaction.
    a_no_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_char |=> !out_valid)
        else $error("result shown for a character that is not last");

    // An incomplete record leaves the held fields untouched.
    a_invalid_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !record_valid |-> $stable(packet_number_value)
            && $stable(pressure_value) && $stable(rssi_value) && $stable(snr_value))
        else $error("held values changed on an incomplete record");

    // An unused selector reports zero.
    a_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_char && field_select == 4'd0
            |=> selected_value == 25'sd0)
        else $error("selector zero gave a nonzero value");

endmodule

bind telemetry_text_field_parser ttfp_checker u_ttfp_checker (.*);

`default_nettype wire
